>>> rtl/core/fhfc_pkg.sv
// Package for the half format converter: request codes and conversion functions.
// Used by fhfc_convert and float_half_format_converter; depends on nothing.
package fhfc_pkg;

   typedef enum logic [1:0] {
      REQ_F32_TO_F16  = 2'd0,
      REQ_F16_TO_F32  = 2'd1,
      REQ_F32_TO_BF16 = 2'd2,
      REQ_BF16_TO_F32 = 2'd3
   } req_type_type;

   localparam logic [30:0] F32_INF_ABS   = 31'h7F800000;
   localparam logic [30:0] F16_OVF_ABS   = 31'h477FF000;
   localparam logic [30:0] F16_NORM_ABS  = 31'h38800000;
   localparam logic [15:0] F16_QNAN      = 16'h7E00;
   localparam logic [15:0] F16_INF       = 16'h7C00;

   function automatic logic [15:0] to_half(input logic [31:0] w);
      logic [14:0] a_hi;
      logic [30:0] a;
      logic [7:0]  e;
      logic [23:0] m;
      logic [7:0]  sh;
      logic [47:0] ext;
      logic [23:0] q;
      logic [23:0] rem;
      logic [23:0] half;
      logic [14:0] mn;
      logic [12:0] r13;
      logic [15:0] res;
      a    = w[30:0];
      e    = a[30:23];
      a_hi = '0;
      res  = '0;
      m    = {1'b1, a[22:0]};
      sh   = 8'd126 - e;
      ext  = {m, 24'd0} >> sh[4:0];
      q    = ext[47:24];
      rem  = ext[23:0];
      half = 24'h800000;
      mn   = {5'(e - 8'd112), a[22:13]};
      r13  = a[12:0];
      if (a > F32_INF_ABS) begin
         res = F16_QNAN;
      end else if (a >= F16_OVF_ABS) begin
         res = F16_INF;
      end else if (a < F16_NORM_ABS) begin
         if (e == 8'd0 || sh > 8'd24) begin
            res = '0;
         end else begin
            if (rem > half || (rem == half && q[0])) begin
               q = q + 24'd1;
            end
            res = {1'b0, q[14:0]};
         end
      end else begin
         if (r13 > 13'h1000 || (r13 == 13'h1000 && mn[0])) begin
            mn = mn + 15'd1;
         end
         res = {1'b0, mn};
      end
      res[15] = w[31];
      a_hi = res[14:0];
      return {w[31], a_hi};
   endfunction

   function automatic logic [31:0] from_half(input logic [15:0] h);
      logic [4:0]  e;
      logic [9:0]  m;
      logic [3:0]  lz;
      logic [10:0] mn;
      logic [7:0]  ex;
      logic [30:0] mag;
      e   = h[14:10];
      m   = h[9:0];
      lz  = 4'd0;
      for (int i = 9; i >= 0; i--) begin
         if (m[i] && lz == 4'd0) begin
            lz = 4'(10 - i);
         end
      end
      mn  = {1'b0, m} << lz;
      ex  = 8'd113 - {4'd0, lz};
      if (e == 5'h1F) begin
         mag = (m == 10'd0) ? F32_INF_ABS : (F32_INF_ABS | 31'h400000 | {8'd0, m, 13'd0});
      end else if (e == 5'd0) begin
         mag = (m == 10'd0) ? 31'd0 : {ex, mn[9:0], 13'd0};
      end else begin
         mag = {{3'd0, e} + 8'd112, m, 13'd0};
      end
      return {h[15], mag};
   endfunction

   function automatic logic [15:0] to_bf16(input logic [31:0] w);
      logic [31:0] s;
      if (w[30:0] > F32_INF_ABS) begin
         return w[31:16] | 16'h0040;
      end
      s = w + 32'h7FFF + {31'd0, w[16]};
      return s[31:16];
   endfunction

endpackage

>>> rtl/core/fhfc_convert.sv
// Combinational conversion of one registered request into a result word.
// Depends on fhfc_pkg.
module fhfc_convert import fhfc_pkg::*; (
   input  logic [1:0]  req_type,
   input  logic [31:0] value_bits,
   output logic [31:0] result_bits
);
   always_comb begin
      case (req_type_type'(req_type))
         REQ_F32_TO_F16:  result_bits = {16'd0, to_half(value_bits)};
         REQ_F16_TO_F32:  result_bits = from_half(value_bits[15:0]);
         REQ_F32_TO_BF16: result_bits = {16'd0, to_bf16(value_bits)};
         default:         result_bits = {value_bits[15:0], 16'd0};
      endcase
   end
endmodule

>>> rtl/core/float_half_format_converter.sv
// Top level of the half format converter: input register, conversion, result register.
// Depends on fhfc_pkg and fhfc_convert.
//
// Converts between binary32 and half or bfloat16 per request. One request is accepted
// every cycle while req_stall is low; the input register and the result register form
// a two-stage pipe that holds under stall.
module float_half_format_converter import fhfc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_type,
   input  logic [31:0] req_value_bits,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_result_bits
);
   logic        s1_valid_ff;
   logic [1:0]  s1_type_ff;
   logic [31:0] s1_value_ff;
   logic        s2_valid_ff;
   logic [31:0] s2_result_ff;
   logic [31:0] s2_result_in;
   logic        s2_move;
   logic        s1_move;

   assign s2_move   = !s2_valid_ff || !rsp_stall;
   assign s1_move   = !s1_valid_ff || s2_move;
   assign req_stall = !s1_move;
   assign rsp_valid = s2_valid_ff;
   assign rsp_result_bits = s2_result_ff;

   fhfc_convert u_convert (
      .req_type    (s1_type_ff),
      .value_bits  (s1_value_ff),
      .result_bits (s2_result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (s2_move) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s1_move) begin
            s1_valid_ff <= req_valid;
         end
      end
      if (s2_move && s1_valid_ff) begin
         s2_result_ff <= s2_result_in;
      end
      if (s1_move && req_valid) begin
         s1_type_ff  <= req_type;
         s1_value_ff <= req_value_bits;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result_bits))
      else $error("result changed under stall");
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && s2_valid_ff && rsp_stall)
      else $error("stall without full pipe");
   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s2_move |=> s2_valid_ff)
      else $error("request lost between stages");
endmodule
